FILE: src/trqr_pkg.sv
package trqr_pkg;

  localparam int unsigned DEPTH   = 8;
  localparam int unsigned PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned VAL_W   = 8;
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned ENTRY_W = 3;

  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [VAL_W-1:0] val_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_TOGGLE  = 2'd0,
    CMD_DEQUEUE = 2'd1,
    CMD_ENQUEUE = 2'd2
  } cmd_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_FINISH,
    ST_POP_RD,
    ST_POP_TAKE,
    ST_HEAD_RD,
    ST_HEAD_TAKE,
    ST_RESULT
  } state_e;

  typedef enum logic {
    RD_SCAN,
    RD_HEAD
  } rd_sel_e;

  typedef struct packed {
    logic    load;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    scan_step;
    logic    finish;
    logic    pop_take;
    logic    head_take;
  } dp_ctrl_t;

  typedef struct packed {
    cmd_e cmd;
    logic empty;
    logic scan_last;
  } dp_stat_t;

  function automatic ptr_t wrap_next(ptr_t p);
    ptr_t r;
    if (p == ptr_t'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + ptr_t'(1);
    end
    return r;
  endfunction

endpackage

FILE: src/trqr_datapath.sv
module trqr_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [trqr_pkg::CMD_W-1:0]     cmd_i,
  input  logic [trqr_pkg::VAL_W-1:0]     req_value_i,
  input  trqr_pkg::dp_ctrl_t             ctrl_i,
  output trqr_pkg::dp_stat_t             stat_o,
  output logic [trqr_pkg::VAL_W-1:0]     popped_value_o,
  output logic                           popped_ok_o,
  output logic                           was_removed_o,
  output logic                           was_dropped_o,
  output logic [trqr_pkg::VAL_W-1:0]     head_value_o,
  output logic                           is_empty_o,
  output logic                           is_full_o,
  output logic [trqr_pkg::ENTRY_W-1:0]   entry_count_o
);
  import trqr_pkg::*;

  val_t slots_q [DEPTH];
  val_t rdata_q;

  ptr_t head_q, tail_q;
  cnt_t count_q;

  ptr_t rd_q, wr_q;
  cnt_t keep_q;
  logic found_q;
  cmd_e cmd_q;
  val_t val_q;

  val_t                 popped_value_q;
  logic                 popped_ok_q, was_removed_q, was_dropped_q;
  val_t                 head_value_q;
  logic                 is_empty_q, is_full_q;
  logic [ENTRY_W-1:0]   entry_count_q;

  logic empty, full, match;
  logic we;
  ptr_t waddr, raddr;
  val_t wdata;

  assign empty = (head_q == tail_q);
  assign full  = (wrap_next(tail_q) == head_q);
  assign match = (rdata_q == val_q);

  assign stat_o.cmd       = cmd_q;
  assign stat_o.empty     = empty;
  assign stat_o.scan_last = (wrap_next(rd_q) == tail_q);

  // One write port: compaction writes a kept entry, an append writes at the tail.
  always_comb begin
    we    = 1'b0;
    waddr = tail_q;
    wdata = val_q;
    if (ctrl_i.scan_step && !match) begin
      we    = 1'b1;
      waddr = wr_q;
      wdata = rdata_q;
    end else if (ctrl_i.finish && !found_q && !full) begin
      we    = 1'b1;
    end
  end

  assign raddr = (ctrl_i.rd_sel == RD_SCAN) ? rd_q : head_q;

  always_ff @(posedge clk_i) begin
    if (we) begin
      slots_q[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd_en) begin
      rdata_q <= slots_q[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      if (ctrl_i.finish) begin
        if (found_q) begin
          tail_q  <= wr_q;
          count_q <= keep_q;
        end else if (!full) begin
          tail_q  <= wrap_next(tail_q);
          count_q <= count_q + cnt_t'(1);
        end
      end
      if (ctrl_i.pop_take) begin
        head_q  <= wrap_next(head_q);
        count_q <= count_q - cnt_t'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cmd_q          <= cmd_e'(cmd_i);
      val_q          <= req_value_i;
      rd_q           <= head_q;
      wr_q           <= head_q;
      keep_q         <= '0;
      found_q        <= 1'b0;
      popped_value_q <= '0;
      popped_ok_q    <= 1'b0;
      was_removed_q  <= 1'b0;
      was_dropped_q  <= 1'b0;
    end
    if (ctrl_i.scan_step) begin
      rd_q <= wrap_next(rd_q);
      if (match) begin
        found_q <= 1'b1;
      end else begin
        wr_q   <= wrap_next(wr_q);
        keep_q <= keep_q + cnt_t'(1);
      end
    end
    if (ctrl_i.finish) begin
      if (found_q) begin
        was_removed_q <= 1'b1;
      end else if (full) begin
        was_dropped_q <= 1'b1;
      end
    end
    if (ctrl_i.pop_take) begin
      popped_value_q <= rdata_q;
      popped_ok_q    <= 1'b1;
    end
    if (ctrl_i.head_take) begin
      head_value_q  <= empty ? '0 : rdata_q;
      is_empty_q    <= empty;
      is_full_q     <= full;
      entry_count_q <= ENTRY_W'(count_q);
    end
  end

  assign popped_value_o = popped_value_q;
  assign popped_ok_o    = popped_ok_q;
  assign was_removed_o  = was_removed_q;
  assign was_dropped_o  = was_dropped_q;
  assign head_value_o   = head_value_q;
  assign is_empty_o     = is_empty_q;
  assign is_full_o      = is_full_q;
  assign entry_count_o  = entry_count_q;

  // The stored count always equals the ring distance from head to tail.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tail_q >= head_q) ? (count_q == cnt_t'(tail_q - head_q))
                       : (count_q == cnt_t'(DEPTH - head_q + tail_q)))
    else $error("stored count disagrees with ring pointers");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.pop_take |=> (count_q == $past(count_q) - cnt_t'(1)))
    else $error("dequeue did not lower the count by one");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.head_take |=> !(is_empty_q && is_full_q))
    else $error("result reports empty and full together");

  // A removal always keeps fewer entries than were stored.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.finish && found_q |-> (keep_q < count_q))
    else $error("removal kept as many entries as were stored");

endmodule

FILE: src/trqr_ctrl.sv
module trqr_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  trqr_pkg::dp_stat_t stat_i,
  output trqr_pkg::dp_ctrl_t ctrl_o
);
  import trqr_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        case (stat_i.cmd)
          CMD_TOGGLE:  state_d = stat_i.empty ? ST_FINISH : ST_SCAN_RD;
          CMD_DEQUEUE: state_d = stat_i.empty ? ST_HEAD_RD : ST_POP_RD;
          CMD_ENQUEUE: state_d = ST_FINISH;
          default:     state_d = ST_HEAD_RD;
        endcase
      end
      ST_SCAN_RD:   state_d = ST_SCAN_CHK;
      ST_SCAN_CHK:  state_d = stat_i.scan_last ? ST_FINISH : ST_SCAN_RD;
      ST_FINISH:    state_d = ST_HEAD_RD;
      ST_POP_RD:    state_d = ST_POP_TAKE;
      ST_POP_TAKE:  state_d = ST_HEAD_RD;
      ST_HEAD_RD:   state_d = ST_HEAD_TAKE;
      ST_HEAD_TAKE: state_d = ST_RESULT;
      ST_RESULT: begin
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default:      state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o       = 1'b0;
    out_valid_o      = 1'b0;
    ctrl_o           = '0;
    ctrl_o.rd_sel    = RD_HEAD;
    case (state_q)
      ST_IDLE: begin
        in_ready_o  = 1'b1;
        ctrl_o.load = in_valid_i;
      end
      ST_SCAN_RD: begin
        ctrl_o.rd_en  = 1'b1;
        ctrl_o.rd_sel = RD_SCAN;
      end
      ST_SCAN_CHK:  ctrl_o.scan_step = 1'b1;
      ST_FINISH:    ctrl_o.finish    = 1'b1;
      ST_POP_RD:    ctrl_o.rd_en     = 1'b1;
      ST_POP_TAKE:  ctrl_o.pop_take  = 1'b1;
      ST_HEAD_RD:   ctrl_o.rd_en     = 1'b1;
      ST_HEAD_TAKE: ctrl_o.head_take = 1'b1;
      ST_RESULT:    out_valid_o      = 1'b1;
      default: begin
      end
    endcase
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input taken while a result is pending");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_DISPATCH))
    else $error("accepted transfer not dispatched");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.head_take |=> out_valid_o)
    else $error("result not presented after status capture");

endmodule

FILE: src/toggle_request_ring_queue.sv
// Ring queue of 8-bit request values with remove-by-value on toggle.
// Input channel: cmd_i and req_value_i move on a valid/ready transfer.
// Toggle removes every stored copy of a present value, keeping the order of
// the rest, or appends an absent value; enqueue appends; dequeue pops the
// head. The queue keeps one slot free and holds at most DEPTH-1 entries.
// Output channel: one result per command, with the popped value, the flags
// and the head, empty, full and count status after the command.
// One command is handled at a time. After the input transfer a dispatch state
// picks the path: a toggle walks the stored entries through the registered
// read port of the slot memory, reading then checking one entry at a time, and
// with an enqueue updates tail and count; a dequeue that pops reads and takes
// the head. Every command then reads the head and captures the status.
// The next command is taken in the cycle after the result transfer.
// While the receiver stalls, the result is held and no new command is taken.
// Reset empties the queue; slot contents are not cleared, and the value of an
// unwritten slot never reaches an output.
module toggle_request_ring_queue (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [trqr_pkg::CMD_W-1:0]     cmd_i,
  input  logic [trqr_pkg::VAL_W-1:0]     req_value_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [trqr_pkg::VAL_W-1:0]     popped_value_o,
  output logic                           popped_ok_o,
  output logic                           was_removed_o,
  output logic                           was_dropped_o,
  output logic [trqr_pkg::VAL_W-1:0]     head_value_o,
  output logic                           is_empty_o,
  output logic                           is_full_o,
  output logic [trqr_pkg::ENTRY_W-1:0]   entry_count_o
);
  import trqr_pkg::*;

  dp_ctrl_t ctrl;
  dp_stat_t stat;

  trqr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  trqr_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd_i),
    .req_value_i    (req_value_i),
    .ctrl_i         (ctrl),
    .stat_o         (stat),
    .popped_value_o (popped_value_o),
    .popped_ok_o    (popped_ok_o),
    .was_removed_o  (was_removed_o),
    .was_dropped_o  (was_dropped_o),
    .head_value_o   (head_value_o),
    .is_empty_o     (is_empty_o),
    .is_full_o      (is_full_o),
    .entry_count_o  (entry_count_o)
  );

endmodule

FILE: tb/sv/toggle_request_ring_queue_tb.sv
module toggle_request_ring_queue_tb;
  import trqr_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int unsigned LONG_HOLD = 250;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned TAIL_CYCLES = 40;

  typedef struct packed {
    val_t               popped_value;
    logic               popped_ok;
    logic               was_removed;
    logic               was_dropped;
    val_t               head_value;
    logic               is_empty;
    logic               is_full;
    logic [ENTRY_W-1:0] entry_count;
  } queue_status_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [CMD_W-1:0]   cmd_i = '0;
  val_t               req_value_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  val_t               popped_value_o;
  logic               popped_ok_o;
  logic               was_removed_o;
  logic               was_dropped_o;
  val_t               head_value_o;
  logic               is_empty_o;
  logic               is_full_o;
  logic [ENTRY_W-1:0] entry_count_o;

  // Stored requests, front first, as the queue should hold them.
  val_t          shadow_ring[$];
  queue_status_t pending_status_q[$];

  int mismatch_cnt = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_requests = 0;
  int holds_served = 0;
  int unsigned quiet_cycles = 0;

  toggle_request_ring_queue u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .cmd_i         (cmd_i),
    .req_value_i   (req_value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .popped_value_o(popped_value_o),
    .popped_ok_o   (popped_ok_o),
    .was_removed_o (was_removed_o),
    .was_dropped_o (was_dropped_o),
    .head_value_o  (head_value_o),
    .is_empty_o    (is_empty_o),
    .is_full_o     (is_full_o),
    .entry_count_o (entry_count_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic queue_status_t apply_request(logic [CMD_W-1:0] c, val_t v);
    queue_status_t st;
    val_t          kept[$];
    bit            hit;
    st  = '0;
    hit = 1'b0;
    case (c)
      CMD_TOGGLE: begin
        foreach (shadow_ring[i]) if (shadow_ring[i] == v) hit = 1'b1;
        if (hit) begin
          foreach (shadow_ring[i]) if (shadow_ring[i] != v) kept.push_back(shadow_ring[i]);
          shadow_ring = kept;
          st.was_removed = 1'b1;
        end else if (shadow_ring.size() == DEPTH - 1) begin
          st.was_dropped = 1'b1;
        end else begin
          shadow_ring.push_back(v);
        end
      end
      CMD_DEQUEUE: begin
        if (shadow_ring.size() != 0) begin
          st.popped_value = shadow_ring.pop_front();
          st.popped_ok    = 1'b1;
        end
      end
      CMD_ENQUEUE: begin
        if (shadow_ring.size() == DEPTH - 1) begin
          st.was_dropped = 1'b1;
        end else begin
          shadow_ring.push_back(v);
        end
      end
      default: begin
      end
    endcase
    st.is_empty    = (shadow_ring.size() == 0);
    st.head_value  = st.is_empty ? val_t'(0) : shadow_ring[0];
    st.is_full     = (shadow_ring.size() == DEPTH - 1);
    st.entry_count = ENTRY_W'(shadow_ring.size());
    return st;
  endfunction

  function automatic void check_field(string field, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      mismatch_cnt++;
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
    end
  endfunction

  // Predict on every input transfer.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      pending_status_q.push_back(apply_request(cmd_i, req_value_i));
    end
  end

  always @(posedge clk_i) begin : result_check
    queue_status_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_status_q.size() == 0) begin
        mismatch_cnt++;
        $error("result transfer with no command outstanding");
      end else begin
        want = pending_status_q.pop_front();
        check_field("popped_value", want.popped_value, popped_value_o);
        check_field("popped_ok", 8'(want.popped_ok), 8'(popped_ok_o));
        check_field("was_removed", 8'(want.was_removed), 8'(was_removed_o));
        check_field("was_dropped", 8'(want.was_dropped), 8'(was_dropped_o));
        check_field("head_value", want.head_value, head_value_o);
        check_field("is_empty", 8'(want.is_empty), 8'(is_empty_o));
        check_field("is_full", 8'(want.is_full), 8'(is_full_o));
        check_field("entry_count", 8'(want.entry_count), 8'(entry_count_o));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("toggle_request_ring_queue_tb NOT OK");
      $finish;
    end
  end

  // Result receiver. A long hold is counted here so that the sender keeps
  // offering commands against a blocked output.
  initial begin : receiver
    forever begin
      @(posedge clk_i);
      if (hold_requests != holds_served) begin
        holds_served++;
        repeat (LONG_HOLD) begin
          out_ready_i <= 1'b0;
          @(posedge clk_i);
        end
      end
      out_ready_i <= ($urandom_range(99, 0) >= rx_idle_pct);
    end
  end

  // Valid stays high between back-to-back commands; it only drops for idle cycles and when the input settles.
  task automatic send_cmd(input logic [CMD_W-1:0] c, input val_t v);
    while ($urandom_range(99, 0) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    cmd_i       <= c;
    req_value_i <= v;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic settle_input();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_status_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed_cases();
    tx_idle_pct = 0;
    rx_idle_pct = 30;
    send_cmd(CMD_DEQUEUE, 8'hA5);   // pop from an empty queue
    send_cmd(CMD_TOGGLE, 8'h00);    // absent value is appended
    send_cmd(CMD_ENQUEUE, 8'hFF);
    send_cmd(CMD_TOGGLE, 8'hFF);    // present value is removed
    send_cmd(CMD_ENQUEUE, 8'h55);
    send_cmd(CMD_ENQUEUE, 8'hAA);
    send_cmd(CMD_ENQUEUE, 8'h00);
    send_cmd(CMD_ENQUEUE, 8'h55);
    send_cmd(CMD_ENQUEUE, 8'h33);
    send_cmd(CMD_ENQUEUE, 8'h55);   // queue is now full
    send_cmd(CMD_ENQUEUE, 8'h77);   // append to a full queue is dropped
    send_cmd(CMD_TOGGLE, 8'h11);    // absent toggle on a full queue is dropped
    send_cmd(CMD_TOGGLE, 8'h55);    // three copies removed, gaps closed
    send_cmd(CMD_UNUSED, 8'hFF);
    send_cmd(CMD_TOGGLE, 8'h00);    // removes the head itself
    send_cmd(CMD_DEQUEUE, 8'h00);
    send_cmd(CMD_DEQUEUE, 8'hFF);
    send_cmd(CMD_DEQUEUE, 8'h00);
    settle_input();
  endtask

  task automatic test_random_traffic(input int n_items, input int tx_pct, input int rx_pct);
    val_t             pool[6];
    int               pop_pct;
    int               roll;
    logic [CMD_W-1:0] c;
    val_t             v;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    pop_pct     = 25;
    for (int i = 0; i < n_items; i++) begin
      // A small value pool makes toggles hit stored entries; the pop rate
      // shifts so the queue swings between empty and full.
      if (i % 40 == 0) begin
        foreach (pool[k]) pool[k] = val_t'($urandom);
        case ($urandom_range(2, 0))
          0:       pop_pct = 10;
          1:       pop_pct = 25;
          default: pop_pct = 45;
        endcase
      end
      roll = $urandom_range(99, 0);
      if (roll < 4) begin
        c = CMD_UNUSED;
      end else if (roll < 4 + pop_pct) begin
        c = CMD_DEQUEUE;
      end else begin
        c = ($urandom_range(1, 0) == 1) ? CMD_TOGGLE : CMD_ENQUEUE;
      end
      v = ($urandom_range(99, 0) < 85) ? pool[$urandom_range(5, 0)] : val_t'($urandom);
      send_cmd(c, v);
    end
    settle_input();
  endtask

  task automatic test_output_backpressure();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_requests++;
    for (int i = 0; i < 30; i++) begin
      send_cmd((i % 3 == 2) ? CMD_DEQUEUE : CMD_TOGGLE, val_t'($urandom_range(7, 0)));
    end
    settle_input();
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_cases();
    test_random_traffic(600, 14, 84);
    test_random_traffic(600, 84, 14);
    test_random_traffic(500, 0, 0);
    test_output_backpressure();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0 && pending_status_q.size() == 0) begin
      $display("toggle_request_ring_queue_tb OK");
    end else begin
      $display("toggle_request_ring_queue_tb NOT OK");
    end
    $finish;
  end

endmodule

FILE: files.f
src/trqr_pkg.sv
src/trqr_datapath.sv
src/trqr_ctrl.sv
src/toggle_request_ring_queue.sv
tb/sv/toggle_request_ring_queue_tb.sv
